// ----- rtl/core/rsa_pkg.sv -----
// Shared types and constants of the running statistics accumulator.
package rsa_pkg;

	// Field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned SUM_W    = 48;
	localparam int unsigned SQ_W     = 63;
	localparam int unsigned MEAN_W   = 24;
	localparam int unsigned VAR_W    = 38;
	localparam int unsigned DEV_W    = 24;
	localparam int unsigned FRAC     = 8;

	// Serial unit widths and step counts
	localparam int unsigned WIDE_W     = 128;
	localparam int unsigned HALF_W     = 64;
	localparam int unsigned STEP_W     = 7;
	localparam int unsigned MUL_STEPS  = 64;
	localparam int unsigned DIV_STEPS  = 128;
	localparam int unsigned SQRT_STEPS = 32;

	// Item modes
	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_MERGE = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	// Store reset values
	localparam logic signed [SAMPLE_W-1:0] MIN_EMPTY = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] MAX_EMPTY = 16'sh8000;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MERGE,
		ST_MEAN,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_D,
		ST_VAR,
		ST_DEV,
		ST_RESP
	} state_t;

endpackage

// ----- rtl/core/rsa_if.sv -----
// Channel interfaces of the running statistics accumulator.
interface rsa_feed_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] sample;
	logic [31:0]        part_count;
	logic signed [47:0] part_sum;
	logic [62:0]        part_sumsq;
	logic signed [15:0] part_min;
	logic signed [15:0] part_max;

	modport source (output valid, mode, sample, part_count, part_sum, part_sumsq,
		part_min, part_max, input ready);
	modport sink (input valid, mode, sample, part_count, part_sum, part_sumsq,
		part_min, part_max, output ready);
endinterface

interface rsa_stats_if;
	logic               valid;
	logic               ready;
	logic [31:0]        total_count;
	logic signed [47:0] total_sum;
	logic [62:0]        total_sumsq;
	logic signed [15:0] smallest;
	logic signed [15:0] largest;
	logic signed [23:0] mean_q8;
	logic [37:0]        variance_q8;
	logic [23:0]        deviation_q8;
	logic               saturated;

	modport source (output valid, total_count, total_sum, total_sumsq, smallest,
		largest, mean_q8, variance_q8, deviation_q8, saturated, input ready);
	modport sink (input valid, total_count, total_sum, total_sumsq, smallest,
		largest, mean_q8, variance_q8, deviation_q8, saturated, output ready);
endinterface

// ----- rtl/core/rsa_unit.sv -----
// Serial arithmetic unit: shift-add multiply, restoring divide, digit square root.
module rsa_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  rsa_pkg::unit_cmd_t  cmd,
	input  logic [127:0]        opa,
	input  logic [63:0]         opb,
	output rsa_pkg::unit_sts_t  sts,
	output logic [127:0]        result
);

	rsa_pkg::unit_op_t op_q;
	logic                  busy_q;
	logic                  done_q;
	logic [6:0]            step_q;
	logic [63:0]           m_q;
	logic [64:0]           hi_q;
	logic [127:0]          lo_q;
	logic [63:0]           bit_q;

	logic [64:0] mul_sum;
	logic [64:0] div_sh;
	logic        div_ge;
	logic [64:0] div_diff;
	logic [64:0] sq_t;
	logic        sq_ge;

	// One step of each operation
	always_comb begin
		mul_sum  = {1'b0, hi_q[63:0]} + (lo_q[0] ? {1'b0, m_q} : 65'd0);
		div_sh   = {hi_q[63:0], lo_q[127]};
		div_ge   = div_sh >= {1'b0, m_q};
		div_diff = div_sh - {1'b0, m_q};
		sq_t     = {1'b0, lo_q[63:0]} + {1'b0, bit_q};
		sq_ge    = {1'b0, hi_q[63:0]} >= sq_t;
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= rsa_pkg::OP_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q   <= cmd.op;
				busy_q <= 1'b1;
				unique case (cmd.op)
					rsa_pkg::OP_MUL:  step_q <= 7'(rsa_pkg::MUL_STEPS - 1);
					rsa_pkg::OP_DIV:  step_q <= 7'(rsa_pkg::DIV_STEPS - 1);
					rsa_pkg::OP_SQRT: step_q <= 7'(rsa_pkg::SQRT_STEPS - 1);
					default:          step_q <= '0;
				endcase
			end else if (busy_q) begin
				step_q <= step_q - 7'd1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands and advance the working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bit_q <= 64'h4000_0000_0000_0000;
			unique case (cmd.op)
				rsa_pkg::OP_MUL: begin
					hi_q <= '0;
					m_q  <= opa[63:0];
					lo_q <= {64'd0, opb};
				end
				rsa_pkg::OP_DIV: begin
					hi_q <= '0;
					m_q  <= opb;
					lo_q <= opa;
				end
				rsa_pkg::OP_SQRT: begin
					m_q  <= opb;
					hi_q <= {1'b0, opa[63:0]};
					lo_q <= '0;
				end
				default: begin
					hi_q <= '0;
					m_q  <= opb;
					lo_q <= opa;
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				rsa_pkg::OP_MUL: begin
					hi_q <= {1'b0, mul_sum[64:1]};
					lo_q <= {lo_q[127:64], mul_sum[0], lo_q[63:1]};
				end
				rsa_pkg::OP_DIV: begin
					hi_q <= div_ge ? div_diff : div_sh;
					lo_q <= {lo_q[126:0], div_ge};
				end
				rsa_pkg::OP_SQRT: begin
					if (sq_ge) begin
						hi_q <= {1'b0, hi_q[63:0] - sq_t[63:0]};
						lo_q <= {64'd0, (lo_q[63:0] >> 1) + bit_q};
					end else begin
						lo_q <= {64'd0, lo_q[63:0] >> 1};
					end
					bit_q <= bit_q >> 2;
				end
				default: begin
					hi_q <= hi_q;
				end
			endcase
		end
	end

	assign result   = (op_q == rsa_pkg::OP_MUL) ? {hi_q[63:0], lo_q[63:0]} : lo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// ----- rtl/core/running_statistics_accumulator.sv -----
// Top level: statistics store, query sequencer and output register.
//
//  channel | role  | payload
//  feed    | sink  | mode, sample, part_count, part_sum, part_sumsq, part_min, part_max
//  stats   | source| totals, extremes, mean_q8, variance_q8, deviation_q8, saturated
//
// Add and merge pass through the merge state; clear leaves the sequencer idle.
// A query on a non-empty store runs on the one serial unit: 128 steps per divide
// (mean and variance), 64 per multiply (three of them), 32 for the square root.
// Reset puts the store to its empty values at once. A result waits in the output
// register; a following query stalls only when it finishes while that is unread.
module running_statistics_accumulator (
	input  logic         clk,
	input  logic         arst_n,
	rsa_feed_if.sink     feed,
	rsa_stats_if.source  stats
);

	rsa_pkg::state_t state_q, state_d;

	// Store
	logic [31:0]        cnt_q;
	logic signed [47:0] sum_q;
	logic [62:0]        sq_q;
	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic               sat_q;

	// Pending merge operand
	logic [31:0]        op_cnt_q;
	logic signed [47:0] op_sum_q;
	logic [62:0]        op_sq_q;
	logic signed [15:0] op_min_q;
	logic signed [15:0] op_max_q;

	// Query working values
	logic signed [23:0] mean_q;
	logic [37:0]        var_q;
	logic [23:0]        dev_q;
	logic [95:0]        a_q;
	logic [95:0]        n_q;
	logic               ge_q;

	// Output register
	logic               out_valid_q;
	logic [31:0]        o_cnt_q;
	logic signed [47:0] o_sum_q;
	logic [62:0]        o_sq_q;
	logic signed [15:0] o_min_q;
	logic signed [15:0] o_max_q;
	logic signed [23:0] o_mean_q;
	logic [37:0]        o_var_q;
	logic [23:0]        o_dev_q;
	logic               o_sat_q;

	rsa_pkg::unit_cmd_t cmd;
	rsa_pkg::unit_sts_t sts;
	logic [127:0]       opa;
	logic [63:0]        opb;
	logic [127:0]       res;

	logic               accept;
	logic [47:0]        mag;
	logic signed [31:0] samp_sq;
	logic [32:0]        nc;
	logic [48:0]        ns;
	logic [63:0]        nq;
	logic               ovf;
	logic               big_m;
	logic [23:0]        mean_n;
	logic               big_v;
	logic               resp_go;

	rsa_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.sts    (sts),
		.result (res)
	);

	assign accept  = feed.valid & feed.ready;
	assign mag     = sum_q[47] ? 48'(-sum_q) : sum_q;
	assign samp_sq = feed.sample * feed.sample;
	assign resp_go = !out_valid_q || stats.ready;

	// Merge sums and overflow check
	always_comb begin
		nc  = {1'b0, cnt_q} + {1'b0, op_cnt_q};
		ns  = {sum_q[47], sum_q} + {op_sum_q[47], op_sum_q};
		nq  = {1'b0, sq_q} + {1'b0, op_sq_q};
		ovf = nc[32] | (ns[48] ^ ns[47]) | nq[63];
	end

	// Saturate the mean quotient
	always_comb begin
		big_m = |res[127:24];
		if (sum_q[47]) begin
			mean_n = (big_m || (res[23] && |res[22:0])) ? 24'h80_0000 : 24'(-res[23:0]);
		end else begin
			mean_n = (big_m || res[23]) ? 24'h7F_FFFF : res[23:0];
		end
		big_v = |res[127:48];
	end

	// Next state and unit commands
	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.op    = rsa_pkg::OP_MUL;
		opa       = '0;
		opb       = '0;
		unique case (state_q)
			rsa_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (feed.mode)
						rsa_pkg::MODE_ADD, rsa_pkg::MODE_MERGE: state_d = rsa_pkg::ST_MERGE;
						rsa_pkg::MODE_QUERY: begin
							if (cnt_q == '0) begin
								state_d = rsa_pkg::ST_RESP;
							end else begin
								cmd.start = 1'b1;
								cmd.op    = rsa_pkg::OP_DIV;
								opa       = {72'd0, mag, 8'd0};
								opb       = {32'd0, cnt_q};
								state_d   = rsa_pkg::ST_MEAN;
							end
						end
						default: state_d = rsa_pkg::ST_IDLE;
					endcase
				end
			end
			rsa_pkg::ST_MERGE: state_d = rsa_pkg::ST_IDLE;
			rsa_pkg::ST_MEAN: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.op    = rsa_pkg::OP_MUL;
					opa       = {65'd0, sq_q};
					opb       = {32'd0, cnt_q};
					state_d   = rsa_pkg::ST_MUL_A;
				end
			end
			rsa_pkg::ST_MUL_A: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.op    = rsa_pkg::OP_MUL;
					opa       = {80'd0, mag};
					opb       = {16'd0, mag};
					state_d   = rsa_pkg::ST_MUL_B;
				end
			end
			rsa_pkg::ST_MUL_B: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.op    = rsa_pkg::OP_MUL;
					opa       = {96'd0, cnt_q};
					opb       = {32'd0, cnt_q};
					state_d   = rsa_pkg::ST_MUL_D;
				end
			end
			rsa_pkg::ST_MUL_D: begin
				if (sts.done) begin
					if (ge_q) begin
						cmd.start = 1'b1;
						cmd.op    = rsa_pkg::OP_DIV;
						opa       = {16'd0, n_q, 16'd0};
						opb       = res[63:0];
						state_d   = rsa_pkg::ST_VAR;
					end else begin
						state_d = rsa_pkg::ST_RESP;
					end
				end
			end
			rsa_pkg::ST_VAR: begin
				if (sts.done) begin
					if (big_v) begin
						state_d = rsa_pkg::ST_RESP;
					end else begin
						cmd.start = 1'b1;
						cmd.op    = rsa_pkg::OP_SQRT;
						opa       = {80'd0, res[47:0]};
						state_d   = rsa_pkg::ST_DEV;
					end
				end
			end
			rsa_pkg::ST_DEV: begin
				if (sts.done) state_d = rsa_pkg::ST_RESP;
			end
			rsa_pkg::ST_RESP: begin
				if (resp_go) state_d = rsa_pkg::ST_IDLE;
			end
			default: state_d = rsa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Update the store: clear, or commit a merge unless it overflows, which sets the saturated flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
			min_q <= rsa_pkg::MIN_EMPTY;
			max_q <= rsa_pkg::MAX_EMPTY;
			sat_q <= 1'b0;
		end else if (accept && feed.mode == rsa_pkg::MODE_CLEAR) begin
			cnt_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
			min_q <= rsa_pkg::MIN_EMPTY;
			max_q <= rsa_pkg::MAX_EMPTY;
			sat_q <= 1'b0;
		end else if (state_q == rsa_pkg::ST_MERGE) begin
			if (ovf) begin
				sat_q <= 1'b1;
			end else begin
				cnt_q <= nc[31:0];
				sum_q <= ns[47:0];
				sq_q  <= nq[62:0];
				if (op_min_q < min_q) min_q <= op_min_q;
				if (op_max_q > max_q) max_q <= op_max_q;
			end
		end
	end

	// Hold the operand of an add or merge
	always_ff @(posedge clk) begin
		if (accept) begin
			if (feed.mode == rsa_pkg::MODE_ADD) begin
				op_cnt_q <= 32'd1;
				op_sum_q <= {{32{feed.sample[15]}}, feed.sample};
				op_sq_q  <= {31'd0, samp_sq};
				op_min_q <= feed.sample;
				op_max_q <= feed.sample;
			end else begin
				op_cnt_q <= feed.part_count;
				op_sum_q <= feed.part_sum;
				op_sq_q  <= feed.part_sumsq;
				op_min_q <= feed.part_min;
				op_max_q <= feed.part_max;
			end
		end
	end

	// Capture query results as the unit finishes each operation
	always_ff @(posedge clk) begin
		if (accept && feed.mode == rsa_pkg::MODE_QUERY) begin
			mean_q <= '0;
			var_q  <= '0;
			dev_q  <= '0;
		end
		if (sts.done) begin
			unique case (state_q)
				rsa_pkg::ST_MEAN:  mean_q <= mean_n;
				rsa_pkg::ST_MUL_A: a_q    <= res[95:0];
				rsa_pkg::ST_MUL_B: begin
					ge_q <= a_q >= res[95:0];
					n_q  <= a_q - res[95:0];
				end
				rsa_pkg::ST_VAR: begin
					var_q <= (big_v || |res[47:46]) ? '1 : res[45:8];
					if (big_v) dev_q <= '1;
				end
				rsa_pkg::ST_DEV: dev_q <= res[23:0];
				default: ge_q <= ge_q;
			endcase
		end
	end

	// Output register: load on a finished query, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rsa_pkg::ST_RESP && resp_go) begin
			out_valid_q <= 1'b1;
		end else if (stats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rsa_pkg::ST_RESP && resp_go) begin
			o_cnt_q  <= cnt_q;
			o_sum_q  <= sum_q;
			o_sq_q   <= sq_q;
			o_min_q  <= min_q;
			o_max_q  <= max_q;
			o_mean_q <= mean_q;
			o_var_q  <= var_q;
			o_dev_q  <= dev_q;
			o_sat_q  <= sat_q;
		end
	end

	assign feed.ready         = (state_q == rsa_pkg::ST_IDLE);
	assign stats.valid        = out_valid_q;
	assign stats.total_count  = o_cnt_q;
	assign stats.total_sum    = o_sum_q;
	assign stats.total_sumsq  = o_sq_q;
	assign stats.smallest     = o_min_q;
	assign stats.largest      = o_max_q;
	assign stats.mean_q8      = o_mean_q;
	assign stats.variance_q8  = o_var_q;
	assign stats.deviation_q8 = o_dev_q;
	assign stats.saturated    = o_sat_q;

endmodule

// ----- sim/tb_running_statistics_accumulator.sv -----
// Testbench of the running statistics accumulator: directed and random items.
`timescale 1ns / 1ps

module tb_running_statistics_accumulator;

	typedef struct {
		logic [1:0]         mode;
		logic signed [15:0] sample;
		logic [31:0]        part_count;
		logic signed [47:0] part_sum;
		logic [62:0]        part_sumsq;
		logic signed [15:0] part_min;
		logic signed [15:0] part_max;
	} feed_item_t;

	typedef struct {
		logic [31:0]        total_count;
		logic signed [47:0] total_sum;
		logic [62:0]        total_sumsq;
		logic signed [15:0] smallest;
		logic signed [15:0] largest;
		logic signed [23:0] mean_q8;
		logic [37:0]        variance_q8;
		logic [23:0]        deviation_q8;
		logic               saturated;
	} stats_item_t;

	logic clk;
	logic arst_n;

	rsa_feed_if  feed ();
	rsa_stats_if stats ();

	running_statistics_accumulator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.stats  (stats)
	);

	// Predicted store
	logic [31:0]        store_count;
	logic signed [47:0] store_sum;
	logic [62:0]        store_sumsq;
	logic signed [15:0] store_min;
	logic signed [15:0] store_max;
	logic               store_sat;

	stats_item_t pending_stats[$];
	int          mismatches;
	bit          no_idle;
	int          hold_off;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Limit on the whole run
	initial begin
		#20_000_000;
		$display("tb_running_statistics_accumulator: errors");
		$finish;
	end

	function automatic logic [63:0] int_root(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	task automatic clear_store();
		store_count = '0;
		store_sum   = '0;
		store_sumsq = '0;
		store_min   = rsa_pkg::MIN_EMPTY;
		store_max   = rsa_pkg::MAX_EMPTY;
		store_sat   = 1'b0;
	endtask

	// Fold a partial into the store, or drop it on overflow
	task automatic fold_partial(logic [31:0] cnt, logic signed [47:0] s, logic [62:0] sq,
		logic signed [15:0] mn, logic signed [15:0] mx);
		logic [63:0] nc;
		longint      ns;
		logic [63:0] nq;
		nc = {32'b0, store_count} + {32'b0, cnt};
		ns = longint'(store_sum) + longint'(s);
		nq = {1'b0, store_sumsq} + {1'b0, sq};
		if (nc[32] || ns > 64'sh7FFF_FFFF_FFFF || ns < -64'sh8000_0000_0000 || nq[63]) begin
			store_sat = 1'b1;
			return;
		end
		store_count = nc[31:0];
		store_sum   = ns[47:0];
		store_sumsq = nq[62:0];
		if (mn < store_min) store_min = mn;
		if (mx > store_max) store_max = mx;
	endtask

	// Work out the statistics a query reports
	function automatic stats_item_t query_stats();
		stats_item_t r;
		logic [63:0]  mag;
		logic [63:0]  qm;
		longint       mean;
		logic [127:0] a;
		logic [127:0] b;
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] q;
		r.total_count  = store_count;
		r.total_sum    = store_sum;
		r.total_sumsq  = store_sumsq;
		r.smallest     = store_min;
		r.largest      = store_max;
		r.saturated    = store_sat;
		r.mean_q8      = '0;
		r.variance_q8  = '0;
		r.deviation_q8 = '0;
		if (store_count != 0) begin
			mag = store_sum < 0 ? 64'(-longint'(store_sum)) : 64'(longint'(store_sum));
			qm = (mag << rsa_pkg::FRAC) / {32'b0, store_count};
			if (qm > 64'h80_0000) qm = 64'h80_0000;
			mean = store_sum < 0 ? -longint'(qm) : longint'(qm);
			if (mean > 64'sh7F_FFFF) mean = 64'sh7F_FFFF;
			r.mean_q8 = mean[23:0];
			a = {96'b0, store_count};
			a = a * {65'b0, store_sumsq};
			b = {64'b0, mag};
			b = b * {64'b0, mag};
			d = {96'b0, store_count};
			d = d * {96'b0, store_count};
			if (a >= b) begin
				n = a - b;
				q = (n << rsa_pkg::FRAC) / d;
				r.variance_q8 = q > 128'h3F_FFFF_FFFF ? 38'h3F_FFFF_FFFF : q[37:0];
				q = (n << (2 * rsa_pkg::FRAC)) / d;
				if (q[127:64] != 0) q = 128'hFF_FFFF;
				else q = {64'b0, int_root(q[63:0])};
				r.deviation_q8 = q > 128'hFF_FFFF ? 24'hFF_FFFF : q[23:0];
			end
		end
		return r;
	endfunction

	// Advance the predictor by one accepted item
	task automatic predict_item(feed_item_t it);
		case (it.mode)
			rsa_pkg::MODE_ADD: begin
				fold_partial(32'd1, 48'(it.sample),
					63'(longint'(it.sample) * longint'(it.sample)), it.sample, it.sample);
			end
			rsa_pkg::MODE_MERGE: begin
				fold_partial(it.part_count, it.part_sum, it.part_sumsq, it.part_min,
					it.part_max);
			end
			rsa_pkg::MODE_CLEAR: begin
				clear_store();
			end
			default: begin
				pending_stats.push_back(query_stats());
			end
		endcase
	endtask

	// Offer one item and hold it until accepted
	task automatic send_item(feed_item_t it);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 9) begin
			feed.valid = 1'b0;
			@(negedge clk);
		end
		feed.valid      = 1'b1;
		feed.mode       = it.mode;
		feed.sample     = it.sample;
		feed.part_count = it.part_count;
		feed.part_sum   = it.part_sum;
		feed.part_sumsq = it.part_sumsq;
		feed.part_min   = it.part_min;
		feed.part_max   = it.part_max;
		do @(posedge clk); while (!feed.ready);
		predict_item(it);
	endtask

	function automatic feed_item_t mk_item(logic [1:0] m, logic signed [15:0] s = 0,
		logic [31:0] pc = 0, logic signed [47:0] ps = 0, logic [62:0] pq = 0,
		logic signed [15:0] pmn = 0, logic signed [15:0] pmx = 0);
		feed_item_t it;
		it.mode       = m;
		it.sample     = s;
		it.part_count = pc;
		it.part_sum   = ps;
		it.part_sumsq = pq;
		it.part_min   = pmn;
		it.part_max   = pmx;
		return it;
	endfunction

	// Drive ready: random idling, long hold-offs on request
	initial begin
		stats.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				stats.ready = 1'b0;
				hold_off = hold_off - 1;
			end else begin
				stats.ready = no_idle || $urandom_range(99) >= 9;
			end
		end
	end

	task automatic report(string field, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t mismatch on %s: expected %h, got %h", $realtime, field, e, a);
		end
	endtask

	// Check each result against the oldest expectation
	initial begin
		stats_item_t e;
		forever begin
			@(posedge clk);
			if (arst_n && stats.valid && stats.ready) begin
				if (pending_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("%t result with none expected", $realtime);
				end else begin
					e = pending_stats.pop_front();
					report("total_count", e.total_count, stats.total_count);
					report("total_sum", 64'(e.total_sum), 64'(stats.total_sum));
					report("total_sumsq", e.total_sumsq, stats.total_sumsq);
					report("smallest", 64'(e.smallest), 64'(stats.smallest));
					report("largest", 64'(e.largest), 64'(stats.largest));
					report("mean_q8", 64'(e.mean_q8), 64'(stats.mean_q8));
					report("variance_q8", e.variance_q8, stats.variance_q8);
					report("deviation_q8", e.deviation_q8, stats.deviation_q8);
					report("saturated", e.saturated, stats.saturated);
				end
			end
		end
	end

	task automatic test_empty_and_extremes();
		send_item(mk_item(rsa_pkg::MODE_QUERY));
		send_item(mk_item(rsa_pkg::MODE_ADD, -16'sd32768));
		send_item(mk_item(rsa_pkg::MODE_ADD, 16'sd32767));
		send_item(mk_item(rsa_pkg::MODE_ADD, 16'sd0));
		send_item(mk_item(rsa_pkg::MODE_QUERY));
	endtask

	task automatic test_merge_cases();
		// zero-count partial still moves the extremes
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 0, 0, 0, -16'sd32768, 16'sd32767));
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 32'd10, 48'sd100, 63'd1500, -16'sd5,
			16'sd40));
		send_item(mk_item(rsa_pkg::MODE_QUERY));
		// inconsistent store: sum squared beyond count times sumsq
		send_item(mk_item(rsa_pkg::MODE_CLEAR));
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 32'd2, 48'sd50000, 63'd1, 16'sd1, 16'sd2));
		send_item(mk_item(rsa_pkg::MODE_QUERY));
	endtask

	task automatic test_overflow_drops();
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 32'd1, 48'sh7FFF_FFFF_FFFF, 0, 0, 0));
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 32'd1, -48'sh8000_0000_0000, 0, 0, 0));
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 32'd1, 0, 63'h7FFF_FFFF_FFFF_FFFF, 0, 0));
		send_item(mk_item(rsa_pkg::MODE_QUERY));
	endtask

	task automatic test_saturated_results();
		send_item(mk_item(rsa_pkg::MODE_CLEAR));
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 32'd1, -48'sh0100_0000_0000,
			63'h4000_0000_0000_0000, 16'sd0, 16'sd0));
		send_item(mk_item(rsa_pkg::MODE_QUERY));
		send_item(mk_item(rsa_pkg::MODE_CLEAR));
		send_item(mk_item(rsa_pkg::MODE_MERGE, 0, 32'd1, 48'sh0100_0000_0000, 0, 0, 0));
		send_item(mk_item(rsa_pkg::MODE_QUERY));
		send_item(mk_item(rsa_pkg::MODE_CLEAR));
		send_item(mk_item(rsa_pkg::MODE_QUERY));
	endtask

	function automatic feed_item_t random_item();
		int          pick;
		logic [31:0] c;
		pick = $urandom_range(99);
		if (pick < 70) begin
			if ($urandom_range(1)) return mk_item(rsa_pkg::MODE_ADD, 16'($urandom));
			return mk_item(rsa_pkg::MODE_ADD, 16'($urandom_range(400)) - 16'sd200);
		end
		if (pick < 78) begin
			if ($urandom_range(9) == 0)
				return mk_item(rsa_pkg::MODE_MERGE, 16'($urandom), $urandom,
					{$urandom, 16'($urandom)}, {31'($urandom), $urandom},
					16'($urandom), 16'($urandom));
			c = $urandom_range(1000);
			return mk_item(rsa_pkg::MODE_MERGE, 16'($urandom), c,
				48'(longint'(c) * (int'($urandom_range(2000)) - 1000)),
				63'(longint'(c) * $urandom_range(1_100_000)),
				16'($urandom_range(2000)) - 16'sd1000, 16'($urandom_range(2000)) - 16'sd1000);
		end
		if (pick < 80) return mk_item(rsa_pkg::MODE_CLEAR, 16'($urandom));
		return mk_item(rsa_pkg::MODE_QUERY, 16'($urandom));
	endfunction

	task automatic test_random_traffic(int n);
		for (int i = 0; i < n; i++) begin
			no_idle = (i >= n / 3) && (i < n / 2);
			send_item(random_item());
		end
		no_idle = 1'b0;
	endtask

	// Hold the receiver off while queries pile up at the input
	task automatic test_backpressure();
		hold_off = 3000;
		for (int i = 0; i < 12; i++) begin
			send_item(mk_item(rsa_pkg::MODE_ADD, 16'($urandom)));
			send_item(mk_item(rsa_pkg::MODE_QUERY));
		end
	endtask

	initial begin
		feed.valid      = 1'b0;
		feed.mode       = rsa_pkg::MODE_ADD;
		feed.sample     = '0;
		feed.part_count = '0;
		feed.part_sum   = '0;
		feed.part_sumsq = '0;
		feed.part_min   = '0;
		feed.part_max   = '0;
		mismatches = 0;
		no_idle    = 1'b0;
		hold_off   = 0;
		clear_store();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_and_extremes();
		test_merge_cases();
		test_overflow_drops();
		test_saturated_results();
		test_random_traffic(1900);
		test_backpressure();

		@(negedge clk);
		feed.valid = 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("tb_running_statistics_accumulator: clean");
		else
			$display("tb_running_statistics_accumulator: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/rsa_pkg.sv
rtl/core/rsa_if.sv
rtl/core/rsa_unit.sv
rtl/core/running_statistics_accumulator.sv
sim/tb_running_statistics_accumulator.sv
